### hw/rtl/fdsp_pkg.sv
// fdsp_pkg: shared constants for the framed decimal speed parser
// no dependencies; used by the channel interfaces and the top level

package fdsp_pkg;

  // default configuration
  localparam int NumFieldsDef     = 4;
  localparam int MaxFieldCharsDef = 9;
  localparam int ValueBitsDef     = 32;

  // fixed payload widths
  localparam int ByteW  = 8;
  localparam int SpeedW = 32;
  localparam int ExtW   = 64;
  localparam int OutSpeeds = 4;

  // framing and character codes
  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChComma  = 8'h2C;
  localparam logic [ByteW-1:0] ChPlus   = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus  = 8'h2D;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChNine   = 8'h39;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;

endpackage

### hw/rtl/fdsp_if.sv
// fdsp_if: valid/ready channel interfaces for received bytes and speed results
// depends on fdsp_pkg

interface fdsp_in_if
  import fdsp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fdsp_out_if
  import fdsp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SpeedW-1:0] speed_first;
  logic [SpeedW-1:0] speed_second;
  logic [SpeedW-1:0] speed_third;
  logic [SpeedW-1:0] speed_fourth;
  logic              field_overlong;

  modport source (output valid, output speed_first, output speed_second,
                  output speed_third, output speed_fourth, output field_overlong,
                  input ready);
  modport sink   (input valid, input speed_first, input speed_second,
                  input speed_third, input speed_fourth, input field_overlong,
                  output ready);
endinterface

### hw/rtl/framed_decimal_speed_parser.sv
// framed_decimal_speed_parser: '$'-framed, comma-separated decimal field parser
// depends on fdsp_pkg and the channel interfaces in fdsp_if.sv
//
//  channel  | dir | payload                                        | handshake
//  ---------+-----+------------------------------------------------+-----------
//  in_ch    | in  | rx_byte[7:0]                                   | valid/ready
//  out_ch   | out | speed_first..speed_fourth[31:0], field_overlong | valid/ready
//
// one item per cycle while the result register is empty or being drained: an
// input register, then the parse update, then the result register, which loads
// as the item that closes the frame is parsed. rst_n is synchronous, active low,
// and clears all control state. a stalled result holds the result register and
// the input register then takes an item only while it is empty.

module framed_decimal_speed_parser
  import fdsp_pkg::*;
#(
  parameter int NUM_FIELDS      = NumFieldsDef,
  parameter int MAX_FIELD_CHARS = MaxFieldCharsDef,
  parameter int VALUE_BITS      = ValueBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  fdsp_in_if.sink     in_ch,
  fdsp_out_if.source  out_ch
);

  localparam int SlotW = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
  localparam int CntW  = $clog2(MAX_FIELD_CHARS + 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_FIELDS - 1);
  localparam logic [CntW-1:0]  CntMax   = CntW'(MAX_FIELD_CHARS);

  typedef logic [VALUE_BITS-1:0] value_t;

  // input register
  logic             in_valid_r;
  logic [ByteW-1:0] byte_r;
  logic             proc;

  // parse state
  logic             in_frame_r, in_frame_nxt;
  logic [SlotW-1:0] slot_r, slot_nxt;
  value_t           acc_r, acc_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic             started_r, started_nxt;
  logic             stopped_r, stopped_nxt;
  logic             ovl_r, ovl_nxt;
  value_t           cap_r   [NUM_FIELDS];
  value_t           cap_nxt [NUM_FIELDS];

  // result register
  logic              out_valid_r;
  logic [SpeedW-1:0] spd_r [OutSpeeds];
  logic [SpeedW-1:0] spd_w [OutSpeeds];
  logic              ovl_out_r;
  logic              emit;

  // stage advance: result register free or draining
  assign proc        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  // character classes
  logic   is_dollar, is_comma, is_digit, is_blank;
  value_t digit, acc_x10, field_val;

  assign is_dollar = (byte_r == ChDollar);
  assign is_comma  = (byte_r == ChComma);
  assign is_digit  = (byte_r >= ChZero) && (byte_r <= ChNine);
  assign is_blank  = (byte_r == ChSpace) || ((byte_r >= ChTab) && (byte_r <= ChCr));
  assign digit     = VALUE_BITS'(byte_r[3:0]);
  assign acc_x10   = (acc_r << 3) + (acc_r << 1) + digit;
  assign field_val = neg_r ? (VALUE_BITS'(0) - acc_r) : acc_r;

  // per-item parse update
  always_comb begin
    in_frame_nxt = in_frame_r;
    slot_nxt     = slot_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    neg_nxt      = neg_r;
    started_nxt  = started_r;
    stopped_nxt  = stopped_r;
    ovl_nxt      = ovl_r;
    cap_nxt      = cap_r;
    emit         = 1'b0;
    if (proc) begin
      if (is_dollar) begin
        in_frame_nxt = 1'b1;
        slot_nxt     = '0;
        ovl_nxt      = 1'b0;
        acc_nxt      = '0;
        cnt_nxt      = '0;
        neg_nxt      = 1'b0;
        started_nxt  = 1'b0;
        stopped_nxt  = 1'b0;
      end else if (in_frame_r) begin
        if (is_comma) begin
          for (int i = 0; i < NUM_FIELDS; i++) begin
            if (slot_r == SlotW'(i)) begin
              cap_nxt[i] = field_val;
            end
          end
          acc_nxt     = '0;
          cnt_nxt     = '0;
          neg_nxt     = 1'b0;
          started_nxt = 1'b0;
          stopped_nxt = 1'b0;
          if (slot_r == LastSlot) begin
            emit         = 1'b1;
            in_frame_nxt = 1'b0;
            slot_nxt     = '0;
            ovl_nxt      = 1'b0;
          end else begin
            slot_nxt = slot_r + SlotW'(1);
          end
        end else begin
          // field length, saturating
          if (cnt_r >= CntMax) begin
            ovl_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CntW'(1);
          end
          // number scan
          if (!stopped_r) begin
            if (is_digit) begin
              started_nxt = 1'b1;
              acc_nxt     = acc_x10;
            end else if (!started_r) begin
              if (is_blank) begin
                started_nxt = 1'b0;
              end else if (byte_r == ChPlus) begin
                started_nxt = 1'b1;
              end else if (byte_r == ChMinus) begin
                started_nxt = 1'b1;
                neg_nxt     = 1'b1;
              end else begin
                started_nxt = 1'b1;
                stopped_nxt = 1'b1;
              end
            end else begin
              stopped_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      slot_r     <= '0;
      acc_r      <= '0;
      cnt_r      <= '0;
      neg_r      <= 1'b0;
      started_r  <= 1'b0;
      stopped_r  <= 1'b0;
      ovl_r      <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      slot_r     <= slot_nxt;
      acc_r      <= acc_nxt;
      cnt_r      <= cnt_nxt;
      neg_r      <= neg_nxt;
      started_r  <= started_nxt;
      stopped_r  <= stopped_nxt;
      ovl_r      <= ovl_nxt;
    end
  end

  // captured fields: the earlier ones rewritten before each result, the last as it is registered
  always_ff @(posedge clk) begin
    cap_r <= cap_nxt;
  end

  // result speeds: earlier fields from storage, last field straight through
  for (genvar k = 0; k < OutSpeeds; k++) begin : g_spd
    if (k < NUM_FIELDS - 1) begin : g_cap
      logic [ExtW-1:0] ext;
      assign ext      = ExtW'(cap_r[k]);
      assign spd_w[k] = ext[SpeedW-1:0];
    end else if (k == NUM_FIELDS - 1) begin : g_last
      logic [ExtW-1:0] ext;
      assign ext      = ExtW'(field_val);
      assign spd_w[k] = ext[SpeedW-1:0];
    end else begin : g_none
      assign spd_w[k] = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      spd_r     <= spd_w;
      ovl_out_r <= ovl_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.speed_first    = spd_r[0];
  assign out_ch.speed_second   = spd_r[1];
  assign out_ch.speed_third    = spd_r[2];
  assign out_ch.speed_fourth   = spd_r[3];
  assign out_ch.field_overlong = ovl_out_r;

endmodule

### tb/sv/tb_framed_decimal_speed_parser.sv
// tb_framed_decimal_speed_parser: self-checking testbench for the framed decimal speed parser
// drives received bytes over fdsp_in_if and checks speed frames on fdsp_out_if against
// a behavioral parser; depends on fdsp_pkg, fdsp_if.sv and the top level

`timescale 1ns / 1ps

module tb_framed_decimal_speed_parser;
  import fdsp_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int ResetCycles   = 11;
  localparam int NumFields     = NumFieldsDef;
  localparam int MaxChars      = MaxFieldCharsDef;
  localparam int ValueW        = ValueBitsDef;
  localparam int RandomItems   = 900;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 8;
  localparam int MaxReports    = 10;
  localparam int TimeoutCycles = 300000;

  typedef enum logic {IdleRandom, IdleNone} idle_mode_e;

  typedef struct packed {
    logic [SpeedW-1:0] speed_first;
    logic [SpeedW-1:0] speed_second;
    logic [SpeedW-1:0] speed_third;
    logic [SpeedW-1:0] speed_fourth;
    logic              field_overlong;
  } speed_frame_t;

  typedef struct {
    string        text;
    bit           typed;
    speed_frame_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  fdsp_in_if  in_ch ();
  fdsp_out_if out_ch ();

  framed_decimal_speed_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // directed frames: empty fields, signs, blanks, trailing text, extremes, restart, open frame
  dir_row_t dir_rows [4] = '{
    '{"x,$,,,,", 1'b1, {32'h0, 32'h0, 32'h0, 32'h0, 1'b0}},
    '{"$-1,+,\t7a,4294967295,", 1'b1,
      {32'hFFFF_FFFF, 32'h0, 32'd7, 32'hFFFF_FFFF, 1'b1}},
    '{"$9$\377,-,\01399,4294967296,", 1'b0, '0},
    '{"$12,3", 1'b0, '0}
  };

  // parser state of the behavioral model
  bit                pr_in_frame;
  int                pr_slot;
  logic [ValueW-1:0] pr_acc;
  logic [3:0]        pr_chars;
  bit                pr_neg;
  bit                pr_started;
  bit                pr_stopped;
  logic [ValueW-1:0] pr_speeds [NumFields];
  bit                pr_overlong;

  speed_frame_t      pending_frames [$];
  logic [ByteW-1:0]  frame_bytes [$];
  int                mismatch_count = 0;
  int                framed_items;
  idle_mode_e        idle_mode;
  bit                hold_off_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int draw_wait();
    return (idle_mode == IdleNone) ? 0 : int'($urandom_range(0, 8));
  endfunction

  function automatic bit is_blank(input logic [ByteW-1:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic void clear_field();
    pr_acc     = '0;
    pr_chars   = '0;
    pr_neg     = 1'b0;
    pr_started = 1'b0;
    pr_stopped = 1'b0;
  endfunction

  // one byte through the behavioral parser; closed is set when a frame completes
  task automatic parse_rx_byte(input logic [ByteW-1:0] c, output bit closed,
                               output speed_frame_t frame);
    logic [ValueW-1:0] v;
    closed = 1'b0;
    frame  = '0;
    if (c == ChDollar) begin
      pr_in_frame = 1'b1;
      pr_slot     = 0;
      pr_overlong = 1'b0;
      clear_field();
    end else if (pr_in_frame) begin
      if (c == ChComma) begin
        v = pr_neg ? ('0 - pr_acc) : pr_acc;
        if (pr_slot < NumFields) pr_speeds[pr_slot] = v;
        pr_slot++;
        clear_field();
        if (pr_slot >= NumFields) begin
          frame.speed_first    = pr_speeds[0];
          frame.speed_second   = pr_speeds[1];
          frame.speed_third    = pr_speeds[2];
          frame.speed_fourth   = pr_speeds[3];
          frame.field_overlong = pr_overlong;
          closed      = 1'b1;
          pr_in_frame = 1'b0;
          pr_slot     = 0;
          pr_overlong = 1'b0;
        end
      end else begin
        // field length, saturating
        if (pr_chars >= MaxChars) pr_overlong = 1'b1;
        else pr_chars++;
        // atoi-style conversion
        if (!pr_stopped) begin
          if (c >= ChZero && c <= ChNine) begin
            pr_started = 1'b1;
            pr_acc     = pr_acc * 10 + (c - ChZero);
          end else if (!pr_started && !is_blank(c)) begin
            pr_started = 1'b1;
            if (c == ChMinus) pr_neg = 1'b1;
            else if (c != ChPlus) pr_stopped = 1'b1;
          end else if (pr_started) begin
            pr_stopped = 1'b1;
          end
        end
      end
    end
  endtask

  // offer one byte after a random gap (none in IdleNone) and run the model once it is taken
  task automatic send_rx_byte(input logic [ByteW-1:0] b, output bit closed,
                              output speed_frame_t got);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    if (pr_in_frame || b == ChDollar) framed_items++;
    parse_rx_byte(b, closed, got);
  endtask

  // sender pause until every expected frame has come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  // random frame: mostly well formed, some broken, some noise
  task automatic build_frame();
    int kind;
    int pos;
    int ndig;
    logic [ByteW-1:0] b;
    frame_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    frame_bytes.push_back(ChDollar);
    for (int f = 0; f < NumFields; f++) begin
      // leading blanks
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2))
          frame_bytes.push_back(($urandom_range(0, 5) == 0) ? ChSpace
                                                            : 8'(ChTab + $urandom_range(0, 4)));
      case ($urandom_range(0, 7))
        0: frame_bytes.push_back(ChPlus);
        1: frame_bytes.push_back(ChMinus);
        default: ;
      endcase
      // mostly short numbers, some long enough to wrap and run over
      ndig = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(6, 12);
      repeat (ndig) frame_bytes.push_back(8'(ChZero + $urandom_range(0, 9)));
      // trailing junk
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 2)) begin
          do b = 8'($urandom_range(0, 255)); while (b == ChDollar || b == ChComma);
          frame_bytes.push_back(b);
        end
      frame_bytes.push_back(ChComma);
    end
    // broken frame: cut short, restarted, or one byte overwritten
    if (kind >= 75) begin
      pos = $urandom_range(1, frame_bytes.size() - 1);
      case ($urandom_range(0, 2))
        0: while (frame_bytes.size() > pos) void'(frame_bytes.pop_back());
        1: frame_bytes.insert(pos, ChDollar);
        default: frame_bytes[pos] = 8'($urandom_range(0, 255));
      endcase
    end
  endtask

  function automatic void check_frame(input speed_frame_t got);
    speed_frame_t want;
    if (pending_frames.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports)
        $display("unexpected speed frame: %h %h %h %h ovl %b", got.speed_first,
                 got.speed_second, got.speed_third, got.speed_fourth, got.field_overlong);
      return;
    end
    want = pending_frames.pop_front();
    if (got.speed_first !== want.speed_first || got.speed_second !== want.speed_second ||
        got.speed_third !== want.speed_third || got.speed_fourth !== want.speed_fourth ||
        got.field_overlong !== want.field_overlong) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports)
        $display("speed frame mismatch: exp %h %h %h %h ovl %b, got %h %h %h %h ovl %b",
                 want.speed_first, want.speed_second, want.speed_third, want.speed_fourth,
                 want.field_overlong, got.speed_first, got.speed_second, got.speed_third,
                 got.speed_fourth, got.field_overlong);
    end
  endfunction

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int stall;
    bit hold_done;
    speed_frame_t got;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req && !hold_done) begin
        stall     = HoldCycles;
        hold_done = 1'b1;
      end else begin
        stall = draw_wait();
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.speed_first    = out_ch.speed_first;
      got.speed_second   = out_ch.speed_second;
      got.speed_third    = out_ch.speed_third;
      got.speed_fourth   = out_ch.speed_fourth;
      got.field_overlong = out_ch.field_overlong;
      check_frame(got);
    end
  end

  // stimulus
  initial begin : byte_source
    bit closed;
    speed_frame_t got;
    int frame_idx;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = '0;
    rst_n          = 1'b0;
    idle_mode      = IdleRandom;
    hold_off_req   = 1'b0;
    framed_items   = 0;
    pr_in_frame    = 1'b0;
    pr_slot        = 0;
    pr_overlong    = 1'b0;
    clear_field();
    foreach (pr_speeds[k]) pr_speeds[k] = '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, typed expectation where given
    foreach (dir_rows[r]) begin
      for (int i = 0; i < dir_rows[r].text.len(); i++) begin
        send_rx_byte(dir_rows[r].text[i], closed, got);
        if (closed) pending_frames.push_back(dir_rows[r].typed ? dir_rows[r].want : got);
      end
    end
    drain_results();

    // random frames
    framed_items = 0;
    frame_idx    = 0;
    while (framed_items < RandomItems) begin
      if (frame_idx % 8 == 0)
        idle_mode = ($urandom_range(0, 3) == 0) ? IdleNone : IdleRandom;
      // back-to-back bytes against a long output stall
      if (frame_idx == 30) begin
        idle_mode    = IdleNone;
        hold_off_req = 1'b1;
      end
      if (frame_idx == 60) drain_results();
      build_frame();
      foreach (frame_bytes[k]) begin
        send_rx_byte(frame_bytes[k], closed, got);
        if (closed) pending_frames.push_back(got);
      end
      frame_idx++;
    end
    in_ch.valid <= 1'b0;

    // wait out the remaining frames and the pipeline
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_frames.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/fdsp_pkg.sv
hw/rtl/fdsp_if.sv
hw/rtl/framed_decimal_speed_parser.sv
tb/sv/tb_framed_decimal_speed_parser.sv
